### rtl/bis_pkg.sv
// Package for the bilinear image scaler: sizes, word types and register codes.
// No dependencies; used by every module of the scaler except bis_ram.
package bis_pkg;

  localparam int unsigned MAX_SRC_WIDTH  = 256;
  localparam int unsigned MAX_SRC_HEIGHT = 256;
  localparam int unsigned FRAC_BITS      = 16;

  localparam int unsigned STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CX_W        = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned CY_W        = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned WW_W        = $clog2(MAX_SRC_WIDTH + 1);
  localparam int unsigned HH_W        = $clog2(MAX_SRC_HEIGHT + 1);

  localparam int unsigned DIM_W  = 9;
  localparam int unsigned STEP_W = 24;
  localparam int unsigned DST_W  = 10;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned PIX_W  = 3 * CH_W;
  localparam int unsigned CFG_W  = 24;

  localparam int unsigned POS_W = DST_W + STEP_W;
  localparam int unsigned INT_W = POS_W - FRAC_BITS;
  localparam int unsigned WGT_W = FRAC_BITS + 1;
  localparam int unsigned HB_W  = CH_W + FRAC_BITS;
  localparam int unsigned ACC_W = CH_W + 2 * FRAC_BITS;

  localparam logic [WGT_W-1:0] ONE_Q   = WGT_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] ROUND_Q = ACC_W'(1) << (2 * FRAC_BITS - 1);

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_X_STEP     = 2'd2,
    CFG_Y_STEP     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  pixel_index;
    logic [CH_W-1:0]   in_red;
    logic [CH_W-1:0]   in_green;
    logic [CH_W-1:0]   in_blue;
    logic [DST_W-1:0]  dst_x;
    logic [DST_W-1:0]  dst_y;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            out_of_range;
  } out_word_t;

  typedef struct packed {
    logic [WW_W-1:0]   width;
    logic [HH_W-1:0]   height;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
  } cfg_t;

  typedef struct packed {
    logic                 is_load;
    logic                 wr_ok;
    logic [ADDR_W-1:0]    waddr;
    logic [PIX_W-1:0]     wdata;
    logic [ADDR_W-1:0]    row0;
    logic [ADDR_W-1:0]    row1;
    logic [CX_W-1:0]      x0;
    logic [CX_W-1:0]      x1;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic                 oor;
  } s3_t;

  typedef struct packed {
    logic [3:0][PIX_W-1:0] pix;
    logic [FRAC_BITS-1:0]  fx;
    logic [FRAC_BITS-1:0]  fy;
    logic                  oor;
  } s4_t;

endpackage

### rtl/bis_ram.sv
// Generic RAM: one write port, two read ports, registered read with enable.
// No dependencies.
module bis_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

### rtl/bis_map.sv
// Coordinate mapping pipeline: step multiply, edge clamp, row address multiply.
// Depends on bis_pkg.
module bis_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bis_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bis_pkg::in_word_t in_data_i,
  output logic              s3_valid_o,
  input  logic              s3_ready_i,
  output bis_pkg::s3_t      s3_o
);

  localparam int unsigned F = bis_pkg::FRAC_BITS;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  logic                             l1_q, wok1_q;
  logic [bis_pkg::ADDR_W-1:0]       wa1_q;
  logic [bis_pkg::PIX_W-1:0]        wd1_q;
  logic [bis_pkg::POS_W-1:0]        px_q, py_q;

  logic                             l2_q, wok2_q, oor2_q;
  logic [bis_pkg::ADDR_W-1:0]       wa2_q;
  logic [bis_pkg::PIX_W-1:0]        wd2_q;
  logic [bis_pkg::CX_W-1:0]         x0_q, x1_q;
  logic [bis_pkg::CY_W-1:0]         y0_q, y1_q;
  logic [F-1:0]                     fx2_q, fy2_q;

  bis_pkg::s3_t                     s3_q;

  logic [bis_pkg::INT_W-1:0]        sx, sy;
  logic                             oor;
  logic [bis_pkg::CX_W-1:0]         x0, x1;
  logic [bis_pkg::CY_W-1:0]         y0, y1;
  logic [bis_pkg::CX_W:0]           x0p;
  logic [bis_pkg::CY_W:0]           y0p;

  assign en3 = !v3_q || s3_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_comb begin
    sx  = px_q[bis_pkg::POS_W-1:F];
    sy  = py_q[bis_pkg::POS_W-1:F];
    oor = (sx >= bis_pkg::INT_W'(cfg_i.width)) || (sy >= bis_pkg::INT_W'(cfg_i.height));
    x0  = sx[bis_pkg::CX_W-1:0];
    y0  = sy[bis_pkg::CY_W-1:0];
    x0p = {1'b0, x0} + (bis_pkg::CX_W+1)'(1);
    y0p = {1'b0, y0} + (bis_pkg::CY_W+1)'(1);
    x1  = (bis_pkg::WW_W'(x0p) < cfg_i.width) ? x0p[bis_pkg::CX_W-1:0] : x0;
    y1  = (bis_pkg::HH_W'(y0p) < cfg_i.height) ? y0p[bis_pkg::CY_W-1:0] : y0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      l1_q   <= (in_data_i.func == bis_pkg::FUNC_LOAD);
      wok1_q <= (32'(in_data_i.pixel_index) < bis_pkg::STORE_DEPTH);
      wa1_q  <= bis_pkg::ADDR_W'(in_data_i.pixel_index);
      wd1_q  <= {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
      px_q   <= bis_pkg::POS_W'(in_data_i.dst_x) * bis_pkg::POS_W'(cfg_i.x_step);
      py_q   <= bis_pkg::POS_W'(in_data_i.dst_y) * bis_pkg::POS_W'(cfg_i.y_step);
    end
    if (en2) begin
      l2_q   <= l1_q;
      wok2_q <= wok1_q;
      wa2_q  <= wa1_q;
      wd2_q  <= wd1_q;
      oor2_q <= oor;
      x0_q   <= x0;
      x1_q   <= x1;
      y0_q   <= y0;
      y1_q   <= y1;
      fx2_q  <= px_q[F-1:0];
      fy2_q  <= py_q[F-1:0];
    end
    if (en3) begin
      s3_q.is_load <= l2_q;
      s3_q.wr_ok   <= wok2_q;
      s3_q.waddr   <= wa2_q;
      s3_q.wdata   <= wd2_q;
      s3_q.row0    <= bis_pkg::ADDR_W'(
                      (bis_pkg::CY_W+bis_pkg::WW_W)'(y0_q) *
                      (bis_pkg::CY_W+bis_pkg::WW_W)'(cfg_i.width));
      s3_q.row1    <= bis_pkg::ADDR_W'(
                      (bis_pkg::CY_W+bis_pkg::WW_W)'(y1_q) *
                      (bis_pkg::CY_W+bis_pkg::WW_W)'(cfg_i.width));
      s3_q.x0      <= x0_q;
      s3_q.x1      <= x1_q;
      s3_q.fx      <= fx2_q;
      s3_q.fy      <= fy2_q;
      s3_q.oor     <= oor2_q;
    end
  end

  assign s3_valid_o = v3_q;
  assign s3_o       = s3_q;

endmodule

### rtl/bis_blend.sv
// Blend pipeline: horizontal then vertical weighting, round half up, result register.
// Depends on bis_pkg.
module bis_blend (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s4_valid_i,
  output logic               s4_ready_o,
  input  bis_pkg::s4_t       s4_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bis_pkg::out_word_t out_data_o
);

  localparam int unsigned F  = bis_pkg::FRAC_BITS;
  localparam int unsigned C  = bis_pkg::CH_W;
  localparam int unsigned MW = bis_pkg::CH_W + bis_pkg::WGT_W;
  localparam int unsigned VW = bis_pkg::HB_W + bis_pkg::WGT_W;

  logic v5_q, vo_q, en5, eno;
  logic [2:0][bis_pkg::HB_W-1:0] top_d, bot_d, top_q, bot_q;
  logic [F-1:0] fy5_q;
  logic         oor5_q;
  logic [2:0][C-1:0] ch_d;
  bis_pkg::out_word_t out_d, out_q;

  assign eno        = !vo_q || out_ready_i;
  assign en5        = !v5_q || eno;
  assign s4_ready_o = en5;

  always_comb begin
    logic [bis_pkg::WGT_W-1:0] wx0, wx1;
    wx0 = bis_pkg::ONE_Q - bis_pkg::WGT_W'(s4_i.fx);
    wx1 = bis_pkg::WGT_W'(s4_i.fx);
    for (int c = 0; c < 3; c++) begin
      top_d[c] = bis_pkg::HB_W'(
        MW'(s4_i.pix[0][bis_pkg::PIX_W-1-C*c -: C]) * MW'(wx0) +
        MW'(s4_i.pix[1][bis_pkg::PIX_W-1-C*c -: C]) * MW'(wx1));
      bot_d[c] = bis_pkg::HB_W'(
        MW'(s4_i.pix[2][bis_pkg::PIX_W-1-C*c -: C]) * MW'(wx0) +
        MW'(s4_i.pix[3][bis_pkg::PIX_W-1-C*c -: C]) * MW'(wx1));
    end
  end

  always_comb begin
    logic [bis_pkg::WGT_W-1:0] wy0, wy1;
    logic [bis_pkg::ACC_W-1:0] acc;
    wy0 = bis_pkg::ONE_Q - bis_pkg::WGT_W'(fy5_q);
    wy1 = bis_pkg::WGT_W'(fy5_q);
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      acc = bis_pkg::ACC_W'(VW'(top_q[c]) * VW'(wy0) + VW'(bot_q[c]) * VW'(wy1))
            + bis_pkg::ROUND_Q;
      ch_d[c] = oor5_q ? '0 : acc[2*F +: C];
    end
    out_d.out_red      = ch_d[0];
    out_d.out_green    = ch_d[1];
    out_d.out_blue     = ch_d[2];
    out_d.out_of_range = oor5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en5) v5_q <= s4_valid_i;
      if (eno) vo_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      top_q  <= top_d;
      bot_q  <= bot_d;
      fy5_q  <= s4_i.fy;
      oor5_q <= s4_i.oor;
    end
    if (eno) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

### rtl/bilinear_image_scaler.sv
// Top level of the bilinear image scaler; config registers, frame store, pipelines.
// Depends on bis_pkg, bis_ram, bis_map and bis_blend.
// Throughput: one word per cycle, loads and requests alike, while the output
// is not stalled; set by the single frame-store access stage, which reads four
// neighbors from two RAM copies.
// Reset: clears pipeline valids and sets the size and step registers to their
// defaults; the frame store is not cleared and holds nothing until loaded.
module bilinear_image_scaler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  bis_pkg::in_word_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output bis_pkg::out_word_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  bis_pkg::cfg_idx_e                cfg_index_i,
  input  logic [bis_pkg::CFG_W-1:0]        cfg_data_i
);

  logic [bis_pkg::DIM_W-1:0]  src_width_q, src_height_q;
  logic [bis_pkg::STEP_W-1:0] x_step_q, y_step_q;
  bis_pkg::cfg_t              cfg;

  logic         s3_valid, s3_ready, blend_ready;
  bis_pkg::s3_t s3;
  bis_pkg::s4_t s4;
  logic         v4_q;
  logic [bis_pkg::FRAC_BITS-1:0] fx4_q, fy4_q;
  logic         oor4_q;
  logic         ram_we;
  logic [bis_pkg::ADDR_W-1:0] a00, a10, a01, a11;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bis_pkg::DIM_W'(256);
      src_height_q <= bis_pkg::DIM_W'(256);
      x_step_q     <= bis_pkg::STEP_W'(65536);
      y_step_q     <= bis_pkg::STEP_W'(65536);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bis_pkg::CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[bis_pkg::DIM_W-1:0];
        bis_pkg::CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[bis_pkg::DIM_W-1:0];
        bis_pkg::CFG_X_STEP:     x_step_q     <= cfg_data_i[bis_pkg::STEP_W-1:0];
        bis_pkg::CFG_Y_STEP:     y_step_q     <= cfg_data_i[bis_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_width_q == '0) begin
      cfg.width = bis_pkg::WW_W'(1);
    end else if (32'(src_width_q) > bis_pkg::MAX_SRC_WIDTH) begin
      cfg.width = bis_pkg::WW_W'(bis_pkg::MAX_SRC_WIDTH);
    end else begin
      cfg.width = bis_pkg::WW_W'(src_width_q);
    end
    if (src_height_q == '0) begin
      cfg.height = bis_pkg::HH_W'(1);
    end else if (32'(src_height_q) > bis_pkg::MAX_SRC_HEIGHT) begin
      cfg.height = bis_pkg::HH_W'(bis_pkg::MAX_SRC_HEIGHT);
    end else begin
      cfg.height = bis_pkg::HH_W'(src_height_q);
    end
    cfg.x_step = x_step_q;
    cfg.y_step = y_step_q;
  end

  bis_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .s3_valid_o (s3_valid),
    .s3_ready_i (s3_ready),
    .s3_o       (s3)
  );

  // frame-store access stage; loads write here and leave the pipeline
  assign s3_ready = !v4_q || blend_ready;
  assign ram_we   = s3_valid && s3_ready && s3.is_load && s3.wr_ok;
  assign a00 = s3.row0 + bis_pkg::ADDR_W'(s3.x0);
  assign a10 = s3.row0 + bis_pkg::ADDR_W'(s3.x1);
  assign a01 = s3.row1 + bis_pkg::ADDR_W'(s3.x0);
  assign a11 = s3.row1 + bis_pkg::ADDR_W'(s3.x1);

  bis_ram #(.WIDTH(bis_pkg::PIX_W), .DEPTH(bis_pkg::STORE_DEPTH)) u_ram_top (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (s3.waddr),
    .wdata_i   (s3.wdata),
    .re_i      (s3_ready),
    .raddr_a_i (a00),
    .raddr_b_i (a10),
    .rdata_a_o (s4.pix[0]),
    .rdata_b_o (s4.pix[1])
  );

  bis_ram #(.WIDTH(bis_pkg::PIX_W), .DEPTH(bis_pkg::STORE_DEPTH)) u_ram_bot (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (s3.waddr),
    .wdata_i   (s3.wdata),
    .re_i      (s3_ready),
    .raddr_a_i (a01),
    .raddr_b_i (a11),
    .rdata_a_o (s4.pix[2]),
    .rdata_b_o (s4.pix[3])
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (s3_ready) begin
      v4_q <= s3_valid && !s3.is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready) begin
      fx4_q  <= s3.fx;
      fy4_q  <= s3.fy;
      oor4_q <= s3.oor;
    end
  end

  assign s4.fx  = fx4_q;
  assign s4.fy  = fy4_q;
  assign s4.oor = oor4_q;

  bis_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s4_valid_i  (v4_q),
    .s4_ready_o  (blend_ready),
    .s4_i        (s4),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_stall_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked output");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_of_range) |->
      (out_data_o.out_red == '0 && out_data_o.out_green == '0 &&
       out_data_o.out_blue == '0))
    else $error("out-of-range word carries nonzero channels");

  a_no_write_on_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid && !s3.is_load) |-> !ram_we)
    else $error("frame store written by a request");

  a_access_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid && !s3_ready) |=> (s3_valid && $stable(a00) && $stable(a11)))
    else $error("access stage changed while stalled");

endmodule

### bench/scaler_checker.sv
`timescale 1ns / 100ps
// Checker for the bilinear image scaler: watches the config, input and output channels,
// predicts each request's pixel from its own frame store copy and compares. Uses bis_pkg.
module scaler_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  bis_pkg::in_word_t         in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  bis_pkg::out_word_t        out_data_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  bis_pkg::cfg_idx_e         cfg_index_i,
  input  logic [bis_pkg::CFG_W-1:0] cfg_data_i,
  output int unsigned               pending_o,
  output int unsigned               fails_o,
  output int unsigned               results_o
);

  logic [bis_pkg::PIX_W-1:0]  pix_mem [bis_pkg::STORE_DEPTH];
  logic [bis_pkg::DIM_W-1:0]  width_q  = 9'd256;
  logic [bis_pkg::DIM_W-1:0]  height_q = 9'd256;
  logic [bis_pkg::STEP_W-1:0] xstep_q  = 24'd65536;
  logic [bis_pkg::STEP_W-1:0] ystep_q  = 24'd65536;
  bis_pkg::out_word_t         pixel_q[$];
  int unsigned                fails = 0;
  int unsigned                results = 0;

  assign pending_o = pixel_q.size();
  assign fails_o   = fails;
  assign results_o = results;

  task automatic report(input string msg);
    if (fails < 30) $display("MISMATCH @%0t: %s", $realtime, msg);
    fails++;
  endtask

  function automatic int unsigned eff_dim(input logic [bis_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    return (v > 256) ? 256 : int'(v);
  endfunction

  function automatic longint unsigned chan(input logic [bis_pkg::PIX_W-1:0] p, input int c);
    return longint'((p >> (16 - 8 * c)) & 24'hFF);
  endfunction

  function automatic bis_pkg::out_word_t blend_pixel(input bis_pkg::in_word_t w);
    bis_pkg::out_word_t        r;
    int unsigned               ew, eh, x0, y0, x1, y1;
    longint unsigned           px, py, sx, sy, fx, fy, tp, bt, acc;
    logic [bis_pkg::PIX_W-1:0] p00, p10, p01, p11;
    ew = eff_dim(width_q);
    eh = eff_dim(height_q);
    px = longint'(w.dst_x) * longint'(xstep_q);
    py = longint'(w.dst_y) * longint'(ystep_q);
    sx = px >> 16;
    sy = py >> 16;
    fx = px & 64'hFFFF;
    fy = py & 64'hFFFF;
    r = '0;
    if (sx >= ew || sy >= eh) begin
      r.out_of_range = 1'b1;
      return r;
    end
    x0 = sx;
    y0 = sy;
    x1 = (x0 + 1 < ew) ? x0 + 1 : x0;
    y1 = (y0 + 1 < eh) ? y0 + 1 : y0;
    p00 = pix_mem[y0 * ew + x0];
    p10 = pix_mem[y0 * ew + x1];
    p01 = pix_mem[y1 * ew + x0];
    p11 = pix_mem[y1 * ew + x1];
    for (int c = 0; c < 3; c++) begin
      tp  = chan(p00, c) * (65536 - fx) + chan(p10, c) * fx;
      bt  = chan(p01, c) * (65536 - fx) + chan(p11, c) * fx;
      acc = (tp * (65536 - fy) + bt * fy + (64'd1 << 31)) >> 32;
      case (c)
        0: r.out_red   = acc[7:0];
        1: r.out_green = acc[7:0];
        default: r.out_blue = acc[7:0];
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bis_pkg::CFG_SRC_WIDTH:  width_q  <= cfg_data_i[bis_pkg::DIM_W-1:0];
          bis_pkg::CFG_SRC_HEIGHT: height_q <= cfg_data_i[bis_pkg::DIM_W-1:0];
          bis_pkg::CFG_X_STEP:     xstep_q  <= cfg_data_i[bis_pkg::STEP_W-1:0];
          bis_pkg::CFG_Y_STEP:     ystep_q  <= cfg_data_i[bis_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.func == bis_pkg::FUNC_LOAD)
          pix_mem[in_data_i.pixel_index] <=
            {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
        else
          pixel_q.push_back(blend_pixel(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        results++;
        if (pixel_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          bis_pkg::out_word_t e;
          e = pixel_q.pop_front();
          if (out_data_i.out_red !== e.out_red)
            report($sformatf("red got %0d exp %0d", out_data_i.out_red, e.out_red));
          if (out_data_i.out_green !== e.out_green)
            report($sformatf("green got %0d exp %0d", out_data_i.out_green, e.out_green));
          if (out_data_i.out_blue !== e.out_blue)
            report($sformatf("blue got %0d exp %0d", out_data_i.out_blue, e.out_blue));
          if (out_data_i.out_of_range !== e.out_of_range)
            report($sformatf("out_of_range got %0b exp %0b",
                             out_data_i.out_of_range, e.out_of_range));
        end
      end
    end
  end
endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Top of the scaler bench: clock, reset, config writes, load and request words, output stalls.
// Depends on bis_pkg, bilinear_image_scaler and scaler_checker.
module testbench;

  localparam int unsigned LIMIT = 600000;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  bis_pkg::in_word_t           in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  bis_pkg::out_word_t          out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  bis_pkg::cfg_idx_e           cfg_index = bis_pkg::CFG_SRC_WIDTH;
  logic [bis_pkg::CFG_W-1:0]   cfg_data = '0;
  int unsigned                 pending, fails, results;
  int unsigned                 cycles = 0;
  int unsigned                 stall_left = 0;
  bit                          hold_req = 0, hold_done = 0, no_idle = 0;
  bit                          loaded [bis_pkg::STORE_DEPTH];
  int unsigned                 cur_w = 256, cur_h = 256;
  logic [bis_pkg::STEP_W-1:0]  cur_xs = 24'd65536, cur_ys = 24'd65536;
  int unsigned                 n_loads = 0, n_reqs = 0, n_oor = 0;

  always #1 clk = ~clk;

  bilinear_image_scaler dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  scaler_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .pending_o(pending), .fails_o(fails), .results_o(results)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // output side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1;
      stall_left <= 250;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send(input bis_pkg::in_word_t w);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.func == bis_pkg::FUNC_LOAD) begin
      loaded[w.pixel_index] = 1;
      n_loads++;
    end else begin
      n_reqs++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input bis_pkg::cfg_idx_e idx,
                           input logic [bis_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      bis_pkg::CFG_SRC_WIDTH:
        cur_w  = (val[8:0] == 0) ? 1 : ((val[8:0] > 256) ? 256 : val[8:0]);
      bis_pkg::CFG_SRC_HEIGHT:
        cur_h  = (val[8:0] == 0) ? 1 : ((val[8:0] > 256) ? 256 : val[8:0]);
      bis_pkg::CFG_X_STEP: cur_xs = val[23:0];
      default:             cur_ys = val[23:0];
    endcase
  endtask

  task automatic set_cfg(input logic [bis_pkg::CFG_W-1:0] w,
                         input logic [bis_pkg::CFG_W-1:0] h,
                         input logic [bis_pkg::CFG_W-1:0] xs,
                         input logic [bis_pkg::CFG_W-1:0] ys);
    drain();
    write_reg(bis_pkg::CFG_SRC_WIDTH, w);
    write_reg(bis_pkg::CFG_SRC_HEIGHT, h);
    write_reg(bis_pkg::CFG_X_STEP, xs);
    write_reg(bis_pkg::CFG_Y_STEP, ys);
  endtask

  function automatic bis_pkg::in_word_t rand_word();
    bis_pkg::in_word_t w;
    w = {$urandom, $urandom, $urandom};
    return w;
  endfunction

  task automatic load_px(input int unsigned addr);
    bis_pkg::in_word_t w;
    w = rand_word();
    w.func = bis_pkg::FUNC_LOAD;
    w.pixel_index = addr[15:0];
    if ($urandom_range(0, 7) == 0) {w.in_red, w.in_green, w.in_blue} = {3{8'hFF}};
    else if ($urandom_range(0, 7) == 0) {w.in_red, w.in_green, w.in_blue} = '0;
    send(w);
  endtask

  task automatic load_region(input int unsigned rows, input int unsigned cols);
    for (int unsigned y = 0; y < rows; y++)
      for (int unsigned x = 0; x < cols; x++)
        load_px(y * cur_w + x);
  endtask

  // true when the request reads only loaded pixels or maps outside the image
  function automatic bit req_safe(input logic [bis_pkg::DST_W-1:0] dx,
                                  input logic [bis_pkg::DST_W-1:0] dy);
    longint unsigned sx, sy;
    int unsigned x1, y1;
    sx = (longint'(dx) * cur_xs) >> 16;
    sy = (longint'(dy) * cur_ys) >> 16;
    if (sx >= cur_w || sy >= cur_h) return 1;
    x1 = (sx + 1 < cur_w) ? sx + 1 : sx;
    y1 = (sy + 1 < cur_h) ? sy + 1 : sy;
    return loaded[sy * cur_w + sx] && loaded[sy * cur_w + x1] &&
           loaded[y1 * cur_w + sx] && loaded[y1 * cur_w + x1];
  endfunction

  task automatic request(input logic [bis_pkg::DST_W-1:0] dx,
                         input logic [bis_pkg::DST_W-1:0] dy);
    bis_pkg::in_word_t w;
    w = rand_word();
    w.func = bis_pkg::FUNC_REQUEST;
    w.dst_x = dx;
    w.dst_y = dy;
    if (!req_safe(dx, dy)) begin
      w.dst_x = 0;
      w.dst_y = 0;
    end
    if ((longint'(w.dst_x) * cur_xs) >> 16 >= cur_w ||
        (longint'(w.dst_y) * cur_ys) >> 16 >= cur_h) n_oor++;
    send(w);
  endtask

  function automatic logic [bis_pkg::DST_W-1:0] pick_dst(
      input logic [bis_pkg::STEP_W-1:0] st, input int unsigned dim);
    longint unsigned lim;
    if ($urandom_range(0, 9) < 2 || st == 0) return $urandom_range(0, 1023);
    lim = ((longint'(dim) << 16) / st) + 1;
    if (lim > 1023) lim = 1023;
    return $urandom_range(0, int'(lim));
  endfunction

  task automatic random_items(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 22) begin
        if ($urandom_range(0, 9) == 0) load_px($urandom_range(0, 65535));
        else load_px($urandom_range(0, cur_w * cur_h - 1));
      end else begin
        request(pick_dst(cur_xs, cur_w), pick_dst(cur_ys, cur_h));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 256x256, unit steps
    load_region(3, 4);
    request(0, 0);
    request(1, 1);
    request(2, 1);
    request(1023, 1023);
    request(0, 300);

    // half-pixel steps on a 4x4 image, edge clamping
    set_cfg(4, 4, 24'h008000, 24'h008000);
    load_region(4, 4);
    request(0, 0);
    request(1, 1);
    request(7, 7);
    request(6, 5);
    request(8, 0);
    request(1023, 0);

    // zero width and height count as one pixel; zero steps
    set_cfg(0, 0, 0, 0);
    load_px(0);
    request(1023, 1023);
    request(0, 0);

    // oversize width clamps to the maximum, full step range
    set_cfg(300, 1, 24'h000001, 24'h000001);
    set_cfg(300, 1, 24'hFFFFFF, 24'h000001);
    load_region(1, 256);
    request(0, 1023);
    request(1, 0);
    request(1023, 1023);

    // single column reuses the 256 pixels loaded above
    set_cfg(1, 256, 24'h000001, 24'h010000);
    random_items(40);

    // second row of a 256x2 image; the first row is already loaded
    set_cfg(256, 2, 24'h00C000, 24'h004000);
    for (int unsigned x = 0; x < 256; x++) load_px(256 + x);
    random_items(60);

    for (int ph = 0; ph < 4; ph++) begin
      int unsigned w, h;
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      set_cfg(w, h, $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 24'h030000),
              $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 24'h030000));
      load_region(cur_h, cur_w);
      no_idle = (ph == 1);
      if (ph == 2) hold_req = 1;
      random_items(15);
      if (ph == 3) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      random_items(15);
      no_idle = 0;
    end

    drain();
    $display("covered %0d loads and %0d requests (%0d outside the image), %0d results",
             n_loads, n_reqs, n_oor, results);
    $display("sizes from 0 to 300, steps from 0 to full scale, long output hold-off");
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
